// File: rtl/core/tced_pkg.sv
// Shared types and constants of the two-car elevator dispatcher.
// No dependencies; used by tced_car and two_car_elevator_dispatcher.
`timescale 1ns / 1ps
`default_nettype none

package tced_pkg;

    localparam int FLOOR_W = 6;
    localparam logic [FLOOR_W-1:0] FLOOR_MAX = 6'd63;
    localparam logic [FLOOR_W-1:0] FLOOR_GROUND = 6'd1;
    localparam logic [FLOOR_W-1:0] FLOOR_COUNT_RESET = 6'd10;

    localparam int QUEUE_DEPTH_DEFAULT = 16;
    localparam int TIME_BITS_DEFAULT = 16;

    typedef enum logic [1:0] {
        MOT_STOP = 2'd0,
        MOT_UP   = 2'd1,
        MOT_DOWN = 2'd2
    } motion_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CAR_A,
        ST_CAR_B
    } state_t;

    typedef struct packed {
        logic [FLOOR_W-1:0] floor;
        motion_t            motion;
        logic               carrying;
        logic               busy;
        logic [FLOOR_W-1:0] pickup;
        logic [FLOOR_W-1:0] target;
    } car_t;

endpackage

`default_nettype wire

// File: rtl/core/tced_car.sv
// One tick of one car: take the head call, move or check arrival, pick direction.
// Depends on tced_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tced_car (
    input  tced_pkg::car_t                    cur,
    input  logic                              take,
    input  logic [tced_pkg::FLOOR_W-1:0]      call_pickup,
    input  logic [tced_pkg::FLOOR_W-1:0]      call_target,
    output tced_pkg::car_t                    nxt
);

    always_comb
    begin
        tced_pkg::car_t     c;
        logic               released;
        logic [tced_pkg::FLOOR_W-1:0] goal;

        c = cur;
        released = 1'b0;
        goal = '0;

        if (take)
        begin
            c.pickup   = call_pickup;
            c.target   = call_target;
            c.busy     = 1'b1;
            c.carrying = 1'b0;
        end

        if (c.busy)
        begin
            case (c.motion)
                tced_pkg::MOT_UP:
                begin
                    if (c.floor < tced_pkg::FLOOR_MAX)
                        c.floor = c.floor + 1'b1;
                end
                tced_pkg::MOT_DOWN:
                begin
                    if (c.floor > tced_pkg::FLOOR_GROUND)
                        c.floor = c.floor - 1'b1;
                end
                default:
                begin
                    if (!c.carrying && c.floor == c.pickup)
                        c.carrying = 1'b1;
                    if (c.carrying && c.floor == c.target)
                        released = 1'b1;
                end
            endcase

            if (!released)
            begin
                goal = c.carrying ? c.target : c.pickup;
                if (c.floor < goal)
                    c.motion = tced_pkg::MOT_UP;
                else if (c.floor > goal)
                    c.motion = tced_pkg::MOT_DOWN;
                else if (!c.carrying)
                begin
                    c.motion   = tced_pkg::MOT_STOP;
                    c.carrying = 1'b1;
                end
                else
                    released = 1'b1;
            end

            if (released)
            begin
                c.busy     = 1'b0;
                c.carrying = 1'b0;
                c.motion   = tced_pkg::MOT_STOP;
            end
        end

        nxt = c;
    end

endmodule

`default_nettype wire

// File: rtl/core/two_car_elevator_dispatcher.sv
// Top level of the two-car elevator dispatcher: call queue memory and tick sequencer.
// Depends on tced_pkg and tced_car.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   Command channel: an item transfers at a rising edge with start high and busy
//   low. func 0 pushes a call (pickup_floor, target_floor, release_time) into the
//   queue; func 1 advances the tick clock and steps car A, then car B.
//   Result channel: done is high for one cycle; the car fields, waiting_calls,
//   call_rejected and clock_now are valid in that cycle. The receiver cannot
//   stall; each result is taken in the cycle it appears.
//   Sequencing: a push's result is registered at its transfer and busy stays low, so a
//   push can follow every cycle while no tick holds busy. A tick holds busy through states
//   ST_CAR_A and ST_CAR_B and reports as it returns to idle: the call queue memory has one
//   read port with a registered output, and each car needs the current head entry in turn.
//   Configuration: floor_count_wdata is written at an edge with floor_count_we high;
//   the user must do so only while idle, unchecked by the block; it affects later pushes only.
//   Reset: asynchronous, clears the clock, queue pointers and both cars (floor 1,
//   stopped, no call) and sets floor_count to 10. Queue contents need no reset.
module two_car_elevator_dispatcher #(
    parameter int QUEUE_DEPTH = tced_pkg::QUEUE_DEPTH_DEFAULT,
    parameter int TIME_BITS   = tced_pkg::TIME_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              floor_count_we,
    input  logic [tced_pkg::FLOOR_W-1:0]      floor_count_wdata,
    input  logic                              start,
    output logic                              busy,
    input  logic                              func,
    input  logic [tced_pkg::FLOOR_W-1:0]      pickup_floor,
    input  logic [tced_pkg::FLOOR_W-1:0]      target_floor,
    input  logic [TIME_BITS-1:0]              release_time,
    output logic                              done,
    output logic [tced_pkg::FLOOR_W-1:0]      car_a_floor,
    output logic [1:0]                        car_a_motion,
    output logic                              car_a_carrying,
    output logic                              car_a_busy,
    output logic [tced_pkg::FLOOR_W-1:0]      car_b_floor,
    output logic [1:0]                        car_b_motion,
    output logic                              car_b_carrying,
    output logic                              car_b_busy,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]  waiting_calls,
    output logic                              call_rejected,
    output logic [TIME_BITS-1:0]              clock_now
);

    localparam int IDX_W  = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int FW     = tced_pkg::FLOOR_W;
    localparam int WORD_W = 2 * FW + TIME_BITS;
    localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(QUEUE_DEPTH);

    tced_pkg::state_t          state_reg, state_next;
    tced_pkg::car_t            car_a_reg, car_a_next;
    tced_pkg::car_t            car_b_reg, car_b_next;
    logic [TIME_BITS-1:0]      clock_reg, clock_next;
    logic [IDX_W-1:0]          head_reg, head_next;
    logic [IDX_W-1:0]          tail_reg, tail_next;
    logic [FILL_W-1:0]         fill_reg, fill_next;
    logic [FW-1:0]             floor_count_reg;
    logic                      done_reg, done_next;
    logic                      rejected_reg, rejected_next;

    logic [WORD_W-1:0]         queue_mem [QUEUE_DEPTH];
    logic [WORD_W-1:0]         rd_data_reg;
    logic [IDX_W-1:0]          rd_addr;
    logic                      wr_en;

    logic                      accept;
    logic                      push_ok;
    logic                      head_due;
    logic                      take_a, take_b;
    logic [FW-1:0]             head_pickup, head_target;
    logic [TIME_BITS-1:0]      head_release;
    logic [IDX_W-1:0]          head_inc;
    tced_pkg::car_t            car_a_step, car_b_step;

    assign accept = start && !busy;
    assign busy   = (state_reg != tced_pkg::ST_IDLE);

    assign push_ok = (fill_reg != FILL_FULL)
                     && (pickup_floor != '0) && (pickup_floor <= floor_count_reg)
                     && (target_floor != '0) && (target_floor <= floor_count_reg);

    assign head_pickup  = rd_data_reg[WORD_W-1 -: FW];
    assign head_target  = rd_data_reg[WORD_W-FW-1 -: FW];
    assign head_release = rd_data_reg[TIME_BITS-1:0];
    assign head_due     = (fill_reg != '0) && (head_release <= clock_reg);
    assign head_inc     = (head_reg == IDX_LAST) ? '0 : head_reg + 1'b1;

    assign take_a = head_due && !car_a_reg.busy;
    assign take_b = head_due && !car_b_reg.busy;

    tced_car u_car_a (
        .cur         (car_a_reg),
        .take        (take_a),
        .call_pickup (head_pickup),
        .call_target (head_target),
        .nxt         (car_a_step)
    );

    tced_car u_car_b (
        .cur         (car_b_reg),
        .take        (take_b),
        .call_pickup (head_pickup),
        .call_target (head_target),
        .nxt         (car_b_step)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tced_pkg::ST_IDLE:
            begin
                if (accept && func)
                    state_next = tced_pkg::ST_CAR_A;
            end
            tced_pkg::ST_CAR_A: state_next = tced_pkg::ST_CAR_B;
            tced_pkg::ST_CAR_B: state_next = tced_pkg::ST_IDLE;
            default:            state_next = tced_pkg::ST_IDLE;
        endcase
    end

    // Datapath controls and register updates.
    always_comb
    begin
        car_a_next    = car_a_reg;
        car_b_next    = car_b_reg;
        clock_next    = clock_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        fill_next     = fill_reg;
        done_next     = 1'b0;
        rejected_next = rejected_reg;
        wr_en         = 1'b0;
        rd_addr       = head_reg;
        unique case (state_reg)
            tced_pkg::ST_IDLE:
            begin
                if (accept && !func)
                begin
                    done_next     = 1'b1;
                    rejected_next = !push_ok;
                    if (push_ok)
                    begin
                        wr_en     = 1'b1;
                        tail_next = (tail_reg == IDX_LAST) ? '0 : tail_reg + 1'b1;
                        fill_next = fill_reg + 1'b1;
                    end
                end
            end
            tced_pkg::ST_CAR_A:
            begin
                car_a_next = car_a_step;
                if (take_a)
                begin
                    head_next = head_inc;
                    fill_next = fill_reg - 1'b1;
                    rd_addr   = head_inc;
                end
            end
            tced_pkg::ST_CAR_B:
            begin
                car_b_next    = car_b_step;
                done_next     = 1'b1;
                rejected_next = 1'b0;
                if (take_b)
                begin
                    head_next = head_inc;
                    fill_next = fill_reg - 1'b1;
                end
                if (clock_reg != '1)
                    clock_next = clock_reg + 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            queue_mem[tail_reg] <= {pickup_floor, target_floor, release_time};
        rd_data_reg <= queue_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= tced_pkg::ST_IDLE;
            car_a_reg       <= '{floor: tced_pkg::FLOOR_GROUND, motion: tced_pkg::MOT_STOP,
                                 carrying: 1'b0, busy: 1'b0, pickup: '0, target: '0};
            car_b_reg       <= '{floor: tced_pkg::FLOOR_GROUND, motion: tced_pkg::MOT_STOP,
                                 carrying: 1'b0, busy: 1'b0, pickup: '0, target: '0};
            clock_reg       <= '0;
            head_reg        <= '0;
            tail_reg        <= '0;
            fill_reg        <= '0;
            floor_count_reg <= tced_pkg::FLOOR_COUNT_RESET;
            done_reg        <= 1'b0;
            rejected_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            car_a_reg    <= car_a_next;
            car_b_reg    <= car_b_next;
            clock_reg    <= clock_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            fill_reg     <= fill_next;
            done_reg     <= done_next;
            rejected_reg <= rejected_next;
            if (floor_count_we)
                floor_count_reg <= floor_count_wdata;
        end
    end

    assign done           = done_reg;
    assign car_a_floor    = car_a_reg.floor;
    assign car_a_motion   = car_a_reg.motion;
    assign car_a_carrying = car_a_reg.carrying;
    assign car_a_busy     = car_a_reg.busy;
    assign car_b_floor    = car_b_reg.floor;
    assign car_b_motion   = car_b_reg.motion;
    assign car_b_carrying = car_b_reg.carrying;
    assign car_b_busy     = car_b_reg.busy;
    assign waiting_calls  = fill_reg;
    assign call_rejected  = rejected_reg;
    assign clock_now      = clock_reg;

endmodule

`default_nettype wire
